// ===== rtl/cidh_pkg.sv =====
// Package for the child identifier hash block: constants, control word types
// and the microcode program. Depends on nothing; the sequencer, lane and top import it.
package cidh_pkg;

    // Hash constants.
    localparam logic [63:0] FNV_PRIME    = 64'd1099511628211;
    localparam logic [63:0] SEED_UPPER   = 64'd14695981039346656037;
    localparam logic [63:0] SEED_LOWER   = 64'd7809847782465536322;
    localparam logic [63:0] FMIX_C1      = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_C2      = 64'hc4ceb9fe1a85ec53;
    localparam int          FMIX_SHIFT   = 33;
    localparam int          FNV_SHIFT    = 40;
    localparam logic [63:0] FNV_PRIME_LO = 64'h1b3;

    // Salts and separator bytes.
    localparam logic [7:0] SALT_PARENT = 8'ha5;
    localparam logic [7:0] SALT_KEY    = 8'h3c;
    localparam logic [7:0] SALT_NAME   = 8'h96;
    localparam logic [7:0] SEP0_UPPER  = 8'hff;
    localparam logic [7:0] SEP0_LOWER  = 8'h5a;
    localparam logic [7:0] SEP1_UPPER  = 8'hfe;
    localparam logic [7:0] SEP1_LOWER  = 8'hc3;

    // Input operation codes.
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_KEY    = 2'd1;
    localparam logic [1:0] OP_NAME   = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    // Program counter width.
    localparam int PC_W = 6;
    typedef logic [PC_W-1:0] t_pc;

    // Lane operations.
    typedef logic [2:0] t_lop;
    localparam t_lop LOP_NOP  = 3'd0;
    localparam t_lop LOP_SEED = 3'd1;
    localparam t_lop LOP_MIX  = 3'd2;
    localparam t_lop LOP_XSH  = 3'd3;
    localparam t_lop LOP_M0   = 3'd4;
    localparam t_lop LOP_M1   = 3'd5;
    localparam t_lop LOP_M2   = 3'd6;

    // Byte sources for a mix step.
    typedef logic [1:0] t_bsrc;
    localparam t_bsrc BSRC_SHIFT = 2'd0;
    localparam t_bsrc BSRC_SEP0  = 2'd1;
    localparam t_bsrc BSRC_SEP1  = 2'd2;

    // Salt selection for bytes from the shift register.
    typedef logic [1:0] t_salt;
    localparam t_salt SALT_SEL_PARENT = 2'd0;
    localparam t_salt SALT_SEL_KEY    = 2'd1;
    localparam t_salt SALT_SEL_NAME   = 2'd2;

    // Jump conditions.
    typedef logic t_jc;
    localparam t_jc JC_NONE   = 1'b0;
    localparam t_jc JC_IFNAME = 1'b1;

    // Program entry points.
    localparam t_pc ENTRY_START  = 6'd0;
    localparam t_pc ENTRY_KEY    = 6'd18;
    localparam t_pc ENTRY_NAME   = 6'd22;
    localparam t_pc NAME_BYTE    = 6'd24;
    localparam t_pc ENTRY_FINISH = 6'd25;
    localparam t_pc LAST_PC      = 6'd34;

    // One microcode control word.
    typedef struct packed {
        t_lop  lop;
        t_bsrc bsrc;
        t_salt salt;
        logic  cst;     // 0 selects the first fmix constant, 1 the second
        t_jc   jc;
        t_pc   target;
        logic  emit;    // step waits for a free output register
        logic  done;    // last step of the routine
    } t_uword;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic   busy;
        logic   step;
        t_uword uw;
    } t_seq_ctl;

    // Control for one hash lane.
    typedef struct packed {
        logic en;
        t_lop lop;
        logic cst;
    } t_lane_ctl;

    // Builds a control word.
    function automatic t_uword uw_make(input t_lop lop, input t_bsrc bsrc, input t_salt salt,
                                       input logic cst, input logic done, input logic emit);
        t_uword w;
        w.lop    = lop;
        w.bsrc   = bsrc;
        w.salt   = salt;
        w.cst    = cst;
        w.jc     = JC_NONE;
        w.target = '0;
        w.emit   = emit;
        w.done   = done;
        return w;
    endfunction

    // The microcode program. Start: seed, 16 parent bytes, separator.
    // Key: four bytes. Name: separator unless already in the name, one byte.
    // Finish: fmix64 on both lanes, then emit and reseed.
    function automatic t_uword ucode_rom(input t_pc a);
        t_uword w;
        w = uw_make(LOP_NOP, BSRC_SHIFT, SALT_SEL_PARENT, 1'b0, 1'b1, 1'b0);
        case (a) inside
            6'd0:           w = uw_make(LOP_SEED, BSRC_SHIFT, SALT_SEL_PARENT, 1'b0, 1'b0, 1'b0);
            [6'd1:6'd16]:   w = uw_make(LOP_MIX, BSRC_SHIFT, SALT_SEL_PARENT, 1'b0, 1'b0, 1'b0);
            6'd17:          w = uw_make(LOP_MIX, BSRC_SEP0, SALT_SEL_PARENT, 1'b0, 1'b1, 1'b0);
            [6'd18:6'd20]:  w = uw_make(LOP_MIX, BSRC_SHIFT, SALT_SEL_KEY, 1'b0, 1'b0, 1'b0);
            6'd21:          w = uw_make(LOP_MIX, BSRC_SHIFT, SALT_SEL_KEY, 1'b0, 1'b1, 1'b0);
            6'd22: begin
                w = uw_make(LOP_NOP, BSRC_SHIFT, SALT_SEL_NAME, 1'b0, 1'b0, 1'b0);
                w.jc     = JC_IFNAME;
                w.target = NAME_BYTE;
            end
            6'd23:          w = uw_make(LOP_MIX, BSRC_SEP1, SALT_SEL_NAME, 1'b0, 1'b0, 1'b0);
            6'd24:          w = uw_make(LOP_MIX, BSRC_SHIFT, SALT_SEL_NAME, 1'b0, 1'b1, 1'b0);
            6'd25:          w = uw_make(LOP_XSH, BSRC_SHIFT, SALT_SEL_PARENT, 1'b0, 1'b0, 1'b0);
            6'd26:          w = uw_make(LOP_M0, BSRC_SHIFT, SALT_SEL_PARENT, 1'b0, 1'b0, 1'b0);
            6'd27:          w = uw_make(LOP_M1, BSRC_SHIFT, SALT_SEL_PARENT, 1'b0, 1'b0, 1'b0);
            6'd28:          w = uw_make(LOP_M2, BSRC_SHIFT, SALT_SEL_PARENT, 1'b0, 1'b0, 1'b0);
            6'd29:          w = uw_make(LOP_XSH, BSRC_SHIFT, SALT_SEL_PARENT, 1'b0, 1'b0, 1'b0);
            6'd30:          w = uw_make(LOP_M0, BSRC_SHIFT, SALT_SEL_PARENT, 1'b1, 1'b0, 1'b0);
            6'd31:          w = uw_make(LOP_M1, BSRC_SHIFT, SALT_SEL_PARENT, 1'b1, 1'b0, 1'b0);
            6'd32:          w = uw_make(LOP_M2, BSRC_SHIFT, SALT_SEL_PARENT, 1'b1, 1'b0, 1'b0);
            6'd33:          w = uw_make(LOP_XSH, BSRC_SHIFT, SALT_SEL_PARENT, 1'b0, 1'b0, 1'b0);
            6'd34:          w = uw_make(LOP_SEED, BSRC_SHIFT, SALT_SEL_PARENT, 1'b0, 1'b1, 1'b1);
            default:        w = uw_make(LOP_NOP, BSRC_SHIFT, SALT_SEL_PARENT, 1'b0, 1'b1, 1'b0);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/cidh_in_if.sv =====
// Input channel of the child identifier hash block: valid, ready and one item.
// Depends on nothing.
interface cidh_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [63:0] parent_high;
    logic [63:0] parent_low;
    logic [15:0] unit_value;

    modport source (output valid, output op, output parent_high, output parent_low,
                    output unit_value, input ready);
    modport sink   (input valid, input op, input parent_high, input parent_low,
                    input unit_value, output ready);
endinterface

// ===== rtl/cidh_out_if.sv =====
// Result channel of the child identifier hash block: valid, ready and one id.
// Depends on nothing.
interface cidh_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic        id_valid;

    modport source (output valid, output id_high, output id_low, output id_valid,
                    input ready);
    modport sink   (input valid, input id_high, input id_low, input id_valid,
                    output ready);
endinterface

// ===== rtl/cidh_seq.sv =====
// Microcode sequencer: program counter, control word table and jumps.
// Depends on cidh_pkg.
module cidh_seq
    import cidh_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_pc      i_entry,
    input  logic     i_in_name,
    input  logic     i_out_free,
    output t_seq_ctl o_ctl
);

    logic   r_busy, n_busy;
    t_pc    r_pc, n_pc;
    t_uword w_uw;
    logic   w_step;

    // Fetch the current control word.
    assign w_uw   = ucode_rom(r_pc);
    assign w_step = r_busy && !(w_uw.emit && !i_out_free);

    // Next program counter.
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (i_start) begin
            n_busy = 1'b1;
            n_pc   = i_entry;
        end else if (w_step) begin
            if (w_uw.done) begin
                n_busy = 1'b0;
            end else if (w_uw.jc == JC_IFNAME && i_in_name) begin
                n_pc = w_uw.target;
            end else begin
                n_pc = r_pc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_ctl.busy = r_busy;
    assign o_ctl.step = w_step;
    assign o_ctl.uw   = w_uw;

    // The program counter never leaves the program while a routine runs.
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_pc <= LAST_PC)
        else $error("program counter outside the program");

    // A stalled emit step holds its place.
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && w_uw.emit && !i_out_free |=> r_busy && $stable(r_pc))
        else $error("emit step left while output was full");

    // A new routine starts only when the previous one is over.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("routine started while busy");

endmodule

// ===== rtl/cidh_lane.sv =====
// One hash lane: FNV-1a byte mix and the fmix64 finalizer built from
// 32x32 partial products. Depends on cidh_pkg.
module cidh_lane
    import cidh_pkg::*;
(
    input  logic        i_clk,
    input  t_lane_ctl   i_ctl,
    input  logic [7:0]  i_byte,
    input  logic [63:0] i_seed,
    output logic [63:0] o_value
);

    logic [63:0] r_value, n_value;
    logic [63:0] r_acc, n_acc;
    logic [63:0] w_x;
    logic [63:0] w_cst;
    logic [31:0] w_mul_a, w_mul_b;
    logic [63:0] w_prod;

    // FNV step input and the fmix constant for this step.
    assign w_x   = r_value ^ {56'd0, i_byte};
    assign w_cst = i_ctl.cst ? FMIX_C2 : FMIX_C1;

    // Shared 32x32 multiplier; the high halves meet only in the upper word.
    assign w_mul_a = (i_ctl.lop == LOP_M1) ? r_value[63:32] : r_value[31:0];
    assign w_mul_b = (i_ctl.lop == LOP_M2) ? w_cst[63:32] : w_cst[31:0];
    assign w_prod  = 64'(w_mul_a) * 64'(w_mul_b);

    // Lane operation.
    always_comb begin
        n_value = r_value;
        n_acc   = r_acc;
        if (i_ctl.en) begin
            unique case (i_ctl.lop)
                LOP_SEED: n_value = i_seed;
                LOP_MIX:  n_value = (w_x << FNV_SHIFT) + (w_x * FNV_PRIME_LO);
                LOP_XSH:  n_value = r_value ^ (r_value >> FMIX_SHIFT);
                LOP_M0:   n_acc   = w_prod;
                LOP_M1:   n_acc   = r_acc + {w_prod[31:0], 32'd0};
                LOP_M2:   n_value = r_acc + {w_prod[31:0], 32'd0};
                default: begin
                    n_value = r_value;
                    n_acc   = r_acc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_acc   <= n_acc;
    end

    assign o_value = r_value;

endmodule

// ===== rtl/child_id_dual_fnv_hash.sv =====
// Child identifier hash block: top level with run checks, byte feed and
// output register. Depends on cidh_pkg, cidh_in_if, cidh_out_if, cidh_seq
// and cidh_lane.
//
// Usage: items arrive on i_in (op, parent_high, parent_low, unit_value) and
// transfer when valid and ready are both high. Start loads the parent id,
// key items add one 16-bit code unit, name items add one byte, and finish
// produces one result on o_out (id_high, id_low, id_valid). Only finish
// produces a result; other items are absorbed.
// Timing: ready is low while the microcode routine of the last item runs.
// The routines take one byte per cycle on both lanes; finish runs three
// xor-shifts and two 64-bit multiplies as three 32x32 partial products
// each, after which the result sits in the output register. Each routine
// starts in the cycle after its transfer, and ready returns in the cycle
// after its last step. Out-of-order items that hash nothing start no
// routine. The byte-serial FNV loop limits the key rate: each code unit
// needs its transfer and four byte steps before the next item is taken.
// Reset: control state clears and the block waits for a start item.
// Stall: the output register holds its result until taken; the next items
// are still accepted and only a following finish waits at its last step.
module child_id_dual_fnv_hash
    import cidh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cidh_in_if.sink     i_in,
    cidh_out_if.source  o_out
);

    // Run phase codes.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_KEY  = 2'd1;
    localparam logic [1:0] PH_NAME = 2'd2;

    logic [1:0]   r_phase, n_phase;
    logic         r_key_seen, n_key_seen;
    logic         r_name_seen, n_name_seen;
    logic         r_run_bad, n_run_bad;
    logic         r_in_name, n_in_name;
    logic         r_ok, n_ok;
    logic [127:0] r_shift, n_shift;
    logic         r_out_valid;
    logic [63:0]  r_id_high, r_id_low;
    logic         r_id_valid;

    logic         w_in_acc;
    logic         w_start;
    t_pc          w_entry;
    logic         w_out_free;
    t_seq_ctl     w_ctl;
    t_lane_ctl    w_lane_ctl;
    logic [7:0]   w_byte_upper, w_byte_lower, w_salt;
    logic [63:0]  w_upper, w_lower;
    logic         w_emit;
    logic         w_ok_final;

    assign i_in.ready = !w_ctl.busy;
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // Run checks and routine selection at each input transfer.
    always_comb begin
        n_phase     = r_phase;
        n_key_seen  = r_key_seen;
        n_name_seen = r_name_seen;
        n_run_bad   = r_run_bad;
        n_in_name   = r_in_name;
        n_ok        = r_ok;
        n_shift     = r_shift;
        w_start     = 1'b0;
        w_entry     = ENTRY_START;
        if (w_in_acc) begin
            unique case (i_in.op)
                OP_START: begin
                    n_phase     = PH_KEY;
                    n_key_seen  = 1'b0;
                    n_name_seen = 1'b0;
                    n_run_bad   = (i_in.parent_high | i_in.parent_low) == 64'd0;
                    n_shift     = {i_in.parent_high, i_in.parent_low};
                    w_start     = 1'b1;
                    w_entry     = ENTRY_START;
                end
                OP_KEY: begin
                    if (r_phase != PH_KEY) begin
                        n_run_bad = 1'b1;
                    end else begin
                        n_key_seen     = 1'b1;
                        n_shift[127:96] = {16'd0, i_in.unit_value};
                        w_start        = 1'b1;
                        w_entry        = ENTRY_KEY;
                    end
                end
                OP_NAME: begin
                    if (r_phase == PH_IDLE) begin
                        n_run_bad = 1'b1;
                    end else begin
                        if (r_phase == PH_KEY) begin
                            if (!r_key_seen) begin
                                n_run_bad = 1'b1;
                            end
                            n_phase   = PH_NAME;
                            n_in_name = 1'b0;
                        end else begin
                            n_in_name = 1'b1;
                        end
                        n_name_seen     = 1'b1;
                        n_shift[127:120] = i_in.unit_value[7:0];
                        w_start         = 1'b1;
                        w_entry         = ENTRY_NAME;
                    end
                end
                OP_FINISH: begin
                    n_ok        = r_phase == PH_NAME && r_key_seen && r_name_seen
                                  && !r_run_bad;
                    n_phase     = PH_IDLE;
                    n_key_seen  = 1'b0;
                    n_name_seen = 1'b0;
                    n_run_bad   = 1'b0;
                    w_start     = 1'b1;
                    w_entry     = ENTRY_FINISH;
                end
                default: begin
                    w_start = 1'b0;
                end
            endcase
        end else if (w_ctl.step && w_ctl.uw.lop == LOP_MIX && w_ctl.uw.bsrc == BSRC_SHIFT) begin
            n_shift = {r_shift[119:0], 8'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_key_seen  <= 1'b0;
            r_name_seen <= 1'b0;
            r_run_bad   <= 1'b0;
            r_in_name   <= 1'b0;
            r_ok        <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_key_seen  <= n_key_seen;
            r_name_seen <= n_name_seen;
            r_run_bad   <= n_run_bad;
            r_in_name   <= n_in_name;
            r_ok        <= n_ok;
        end
        r_shift <= n_shift;
    end

    // Microcode sequencer.
    cidh_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_entry    (w_entry),
        .i_in_name  (r_in_name),
        .i_out_free (w_out_free),
        .o_ctl      (w_ctl)
    );

    // Byte feed: the lower lane takes salted bytes or its own separators.
    always_comb begin
        unique case (w_ctl.uw.salt)
            SALT_SEL_KEY:  w_salt = SALT_KEY;
            SALT_SEL_NAME: w_salt = SALT_NAME;
            default:       w_salt = SALT_PARENT;
        endcase
        unique case (w_ctl.uw.bsrc)
            BSRC_SEP0: begin
                w_byte_upper = SEP0_UPPER;
                w_byte_lower = SEP0_LOWER;
            end
            BSRC_SEP1: begin
                w_byte_upper = SEP1_UPPER;
                w_byte_lower = SEP1_LOWER;
            end
            default: begin
                w_byte_upper = r_shift[127:120];
                w_byte_lower = r_shift[127:120] ^ w_salt;
            end
        endcase
    end

    assign w_lane_ctl.en  = w_ctl.step;
    assign w_lane_ctl.lop = w_ctl.uw.lop;
    assign w_lane_ctl.cst = w_ctl.uw.cst;

    cidh_lane u_lane_upper (
        .i_clk   (i_clk),
        .i_ctl   (w_lane_ctl),
        .i_byte  (w_byte_upper),
        .i_seed  (SEED_UPPER),
        .o_value (w_upper)
    );

    cidh_lane u_lane_lower (
        .i_clk   (i_clk),
        .i_ctl   (w_lane_ctl),
        .i_byte  (w_byte_lower),
        .i_seed  (SEED_LOWER),
        .o_value (w_lower)
    );

    // Output register, loaded by the emit step.
    assign w_emit     = w_ctl.step && w_ctl.uw.emit;
    assign w_ok_final = r_ok && ((w_upper | w_lower) != 64'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_emit) begin
            r_id_high  <= w_ok_final ? w_upper : 64'd0;
            r_id_low   <= w_ok_final ? w_lower : 64'd0;
            r_id_valid <= w_ok_final;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.id_high  = r_id_high;
    assign o_out.id_low   = r_id_low;
    assign o_out.id_valid = r_id_valid;

    // A result is only presented after an emit step.
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_emit))
        else $error("result appeared without an emit step");

    // An emit step always leaves a result waiting.
    a_emit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> o_out.valid)
        else $error("emit step lost its result");

    // Run checks change only on an input transfer.
    a_flags_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> $stable(r_phase) && $stable(r_run_bad) && $stable(r_key_seen))
        else $error("run state changed without an input transfer");

endmodule
